// ===== src/ubf_pkg.sv =====
// Shared types, constants and ring helpers for the buffered UART front end.
package ubf_pkg;

   // Ring sizes and field widths
   localparam int RX_DEPTH = 256;
   localparam int TX_DEPTH = 256;
   localparam int RX_PTR_W = $clog2(RX_DEPTH);
   localparam int TX_PTR_W = $clog2(TX_DEPTH);
   localparam int DATA_W   = 8;
   localparam int LEN_W    = 8;
   localparam int CNT_W    = 8;
   localparam int OP_W     = 3;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DATA_W = 8;

   localparam logic [DATA_W-1:0] IDLE_TICKS_RESET = 8'd4;

   typedef enum logic [OP_W-1:0] {
      OP_RX_BYTE    = 3'd0,
      OP_HOST_READ  = 3'd1,
      OP_HOST_WRITE = 3'd2,
      OP_TX_REQUEST = 3'd3,
      OP_TICK       = 3'd4,
      OP_POLL       = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_IDLE_TICKS     = 1'b0,
      REG_EVENTS_ENABLED = 1'b1
   } reg_type;

   typedef enum logic {
      ST_IDLE,
      ST_READ
   } state_type;

   typedef enum logic {
      SRC_RX,
      SRC_TX
   } read_src_type;

   typedef struct packed {
      logic [DATA_W-1:0] read_byte;
      logic              read_valid;
      logic              write_accepted;
      logic [DATA_W-1:0] line_byte;
      logic              line_valid;
      logic              rx_overflow;
      logic              evt_rx_full;
      logic              evt_rx_timeout;
      logic              evt_tx_empty;
      logic [CNT_W-1:0]  rx_count;
   } rsp_type;

   // Advance a receive ring pointer with wrap
   function automatic logic [RX_PTR_W-1:0] rx_next(input logic [RX_PTR_W-1:0] p);
      return (p == RX_PTR_W'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Advance a transmit ring pointer with wrap
   function automatic logic [TX_PTR_W-1:0] tx_next(input logic [TX_PTR_W-1:0] p);
      return (p == TX_PTR_W'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // Bytes held in the receive ring
   function automatic logic [RX_PTR_W-1:0] rx_fill(input logic [RX_PTR_W-1:0] rp,
                                                   input logic [RX_PTR_W-1:0] wp);
      logic [RX_PTR_W:0] wide;
      if (wp >= rp) begin
         wide = {1'b0, wp} - {1'b0, rp};
      end else begin
         wide = (RX_PTR_W + 1)'(RX_DEPTH) - {1'b0, rp} + {1'b0, wp};
      end
      return wide[RX_PTR_W-1:0];
   endfunction

   // Bytes held in the transmit ring
   function automatic logic [TX_PTR_W-1:0] tx_fill(input logic [TX_PTR_W-1:0] rp,
                                                   input logic [TX_PTR_W-1:0] wp);
      logic [TX_PTR_W:0] wide;
      if (wp >= rp) begin
         wide = {1'b0, wp} - {1'b0, rp};
      end else begin
         wide = (TX_PTR_W + 1)'(TX_DEPTH) - {1'b0, rp} + {1'b0, wp};
      end
      return wide[TX_PTR_W-1:0];
   endfunction

endpackage

// ===== src/ubf_ifs.sv =====
// Valid/ready channel interfaces for requests, responses and register writes.
interface ubf_req_if;
   logic                         valid;
   logic                         ready;
   logic [ubf_pkg::OP_W-1:0]     op;
   logic [ubf_pkg::DATA_W-1:0]   data_in;
   logic                         burst_first;
   logic [ubf_pkg::LEN_W-1:0]    burst_len;

   modport source (output valid, op, data_in, burst_first, burst_len, input ready);
   modport sink (input valid, op, data_in, burst_first, burst_len, output ready);
endinterface

interface ubf_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ubf_pkg::DATA_W-1:0]   read_byte;
   logic                         read_valid;
   logic                         write_accepted;
   logic [ubf_pkg::DATA_W-1:0]   line_byte;
   logic                         line_valid;
   logic                         rx_overflow;
   logic                         evt_rx_full;
   logic                         evt_rx_timeout;
   logic                         evt_tx_empty;
   logic [ubf_pkg::CNT_W-1:0]    rx_count;

   modport source (output valid, read_byte, read_valid, write_accepted, line_byte,
                   line_valid, rx_overflow, evt_rx_full, evt_rx_timeout, evt_tx_empty,
                   rx_count, input ready);
   modport sink (input valid, read_byte, read_valid, write_accepted, line_byte,
                 line_valid, rx_overflow, evt_rx_full, evt_rx_timeout, evt_tx_empty,
                 rx_count, output ready);
endinterface

interface ubf_csr_if;
   logic                            valid;
   logic                            ready;
   logic [ubf_pkg::CSR_IDX_W-1:0]   index;
   logic [ubf_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== src/ubf_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module ubf_ram #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/uart_buffered_fifo_with_idle_timeout.sv =====
// Top level: receive and transmit rings, idle countdown, poll events, response register.
//
//  channel   direction  payload                                   transfer when
//  req_ch    in         op, data_in, burst_first, burst_len       valid && ready
//  rsp_ch    out        read/write/line results, events, rx_count valid && ready
//  csr_ch    in         index, data (0 idle_ticks, 1 events_en)   valid && ready
//
// Host read and tx request items that find data first read the ring memory, then
// load the response register; all other items load the response register directly.
// Reset (synchronous) empties both rings, clears the countdown and flags, and
// restores idle_ticks to 4 and events disabled. No clearing pass is needed.
// The block takes a request while a response waits only if that response leaves
// in the same cycle; register writes are taken in any cycle outside reset.
module uart_buffered_fifo_with_idle_timeout (
   input  logic   clock,
   input  logic   reset,
   ubf_req_if.sink   req_ch,
   ubf_rsp_if.source rsp_ch,
   ubf_csr_if.sink   csr_ch
);

   // Control state
   ubf_pkg::state_type              state_ff, state_in;
   logic [ubf_pkg::RX_PTR_W-1:0]    rx_rp_ff, rx_rp_in, rx_wp_ff, rx_wp_in;
   logic [ubf_pkg::TX_PTR_W-1:0]    tx_rp_ff, tx_rp_in, tx_wp_ff, tx_wp_in;
   logic [ubf_pkg::DATA_W-1:0]      idle_left_ff, idle_left_in;
   logic                            ran_empty_ff, ran_empty_in;
   logic                            burst_ok_ff, burst_ok_in;
   logic [ubf_pkg::DATA_W-1:0]      idle_ticks_ff;
   logic                            events_en_ff;
   logic                            rsp_valid_ff, rsp_valid_in;

   // Payload registers
   ubf_pkg::rsp_type                rsp_data_ff, rsp_data_in;
   ubf_pkg::rsp_type                pend_ff, pend_in;
   ubf_pkg::read_src_type           src_ff, src_in;

   // Item decode and memory controls
   ubf_pkg::op_type                 op;
   ubf_pkg::rsp_type                rsp_new;
   ubf_pkg::read_src_type           src_new;
   logic                            item_go, out_free, read_hit;
   logic                            rx_wr_en, rx_rd_en, tx_wr_en, tx_rd_en;
   logic [ubf_pkg::DATA_W-1:0]      rx_rd_data, tx_rd_data;
   logic [ubf_pkg::RX_PTR_W-1:0]    rx_cnt;
   logic [ubf_pkg::TX_PTR_W-1:0]    tx_cnt, tx_free;
   logic                            rx_full, tx_full, fits, ok;

   assign op       = ubf_pkg::op_type'(req_ch.op);
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign item_go  = req_ch.valid && req_ch.ready;
   assign csr_ch.ready = !reset;

   // Take a request only when idle and the response register can take its result
   assign req_ch.ready = !reset && out_free && (state_ff == ubf_pkg::ST_IDLE);

   assign rx_cnt  = ubf_pkg::rx_fill(rx_rp_ff, rx_wp_ff);
   assign tx_cnt  = ubf_pkg::tx_fill(tx_rp_ff, tx_wp_ff);
   assign rx_full = (rx_cnt == ubf_pkg::RX_PTR_W'(ubf_pkg::RX_DEPTH - 1));
   assign tx_full = (tx_cnt == ubf_pkg::TX_PTR_W'(ubf_pkg::TX_DEPTH - 1));
   assign tx_free = ubf_pkg::TX_PTR_W'(ubf_pkg::TX_DEPTH - 1) - tx_cnt;
   assign fits    = (req_ch.burst_len <= ubf_pkg::LEN_W'(tx_free));
   assign ok      = req_ch.burst_first ? fits : burst_ok_ff;

   // Ring memories
   ubf_ram #(.DEPTH(ubf_pkg::RX_DEPTH), .WIDTH(ubf_pkg::DATA_W)) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_wr_en),
      .wr_addr (rx_wp_ff),
      .wr_data (req_ch.data_in),
      .rd_en   (rx_rd_en),
      .rd_addr (rx_rp_ff),
      .rd_data (rx_rd_data)
   );

   ubf_ram #(.DEPTH(ubf_pkg::TX_DEPTH), .WIDTH(ubf_pkg::DATA_W)) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_wr_en),
      .wr_addr (tx_wp_ff),
      .wr_data (req_ch.data_in),
      .rd_en   (tx_rd_en),
      .rd_addr (tx_rp_ff),
      .rd_data (tx_rd_data)
   );

   // Decode an accepted item: update pointers, flags and countdown, build the result
   always_comb begin
      rx_rp_in     = rx_rp_ff;
      rx_wp_in     = rx_wp_ff;
      tx_rp_in     = tx_rp_ff;
      tx_wp_in     = tx_wp_ff;
      idle_left_in = idle_left_ff;
      ran_empty_in = ran_empty_ff;
      burst_ok_in  = burst_ok_ff;
      rx_wr_en     = 1'b0;
      rx_rd_en     = 1'b0;
      tx_wr_en     = 1'b0;
      tx_rd_en     = 1'b0;
      read_hit     = 1'b0;
      src_new      = ubf_pkg::SRC_RX;
      rsp_new      = '0;
      if (item_go) begin
         unique case (op)
            ubf_pkg::OP_RX_BYTE: begin
               if (rx_full) begin
                  rsp_new.rx_overflow = 1'b1;
               end else begin
                  rx_wr_en = 1'b1;
                  rx_wp_in = ubf_pkg::rx_next(rx_wp_ff);
               end
               idle_left_in = idle_ticks_ff;
            end
            ubf_pkg::OP_HOST_READ: begin
               if (rx_rp_ff != rx_wp_ff) begin
                  rx_rd_en = 1'b1;
                  rx_rp_in = ubf_pkg::rx_next(rx_rp_ff);
                  read_hit = 1'b1;
                  src_new  = ubf_pkg::SRC_RX;
                  rsp_new.read_valid = 1'b1;
               end
            end
            ubf_pkg::OP_HOST_WRITE: begin
               burst_ok_in = ok;
               if (ok && !tx_full) begin
                  tx_wr_en     = 1'b1;
                  tx_wp_in     = ubf_pkg::tx_next(tx_wp_ff);
                  ran_empty_in = 1'b0;
                  rsp_new.write_accepted = 1'b1;
               end
            end
            ubf_pkg::OP_TX_REQUEST: begin
               if (tx_rp_ff == tx_wp_ff) begin
                  ran_empty_in = 1'b1;
               end else begin
                  tx_rd_en = 1'b1;
                  tx_rp_in = ubf_pkg::tx_next(tx_rp_ff);
                  read_hit = 1'b1;
                  src_new  = ubf_pkg::SRC_TX;
                  rsp_new.line_valid = 1'b1;
               end
            end
            ubf_pkg::OP_TICK: begin
               if (idle_left_ff != '0) begin
                  idle_left_in = idle_left_ff - 1'b1;
               end
            end
            ubf_pkg::OP_POLL: begin
               if (events_en_ff) begin
                  rsp_new.evt_rx_full    = rx_full;
                  rsp_new.evt_rx_timeout = !rx_full && (rx_cnt != '0) &&
                                           (idle_left_ff == '0);
                  rsp_new.evt_tx_empty   = ran_empty_ff;
                  ran_empty_in           = 1'b0;
               end
            end
            default: begin
            end
         endcase
         rsp_new.rx_count = ubf_pkg::CNT_W'(ubf_pkg::rx_fill(rx_rp_in, rx_wp_in));
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ubf_pkg::ST_IDLE: begin
            if (item_go && read_hit) begin
               state_in = ubf_pkg::ST_READ;
            end
         end
         ubf_pkg::ST_READ: begin
            if (out_free) begin
               state_in = ubf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ubf_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs: response load, pending read capture
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in  = rsp_data_ff;
      pend_in      = pend_ff;
      src_in       = src_ff;
      unique case (state_ff)
         ubf_pkg::ST_IDLE: begin
            if (item_go) begin
               if (read_hit) begin
                  pend_in = rsp_new;
                  src_in  = src_new;
               end else begin
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = rsp_new;
               end
            end
         end
         ubf_pkg::ST_READ: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pend_ff;
               if (src_ff == ubf_pkg::SRC_RX) begin
                  rsp_data_in.read_byte = rx_rd_data;
               end else begin
                  rsp_data_in.line_byte = tx_rd_data;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ubf_pkg::ST_IDLE;
         rx_rp_ff     <= '0;
         rx_wp_ff     <= '0;
         tx_rp_ff     <= '0;
         tx_wp_ff     <= '0;
         idle_left_ff <= '0;
         ran_empty_ff <= 1'b0;
         burst_ok_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_rp_ff     <= rx_rp_in;
         rx_wp_ff     <= rx_wp_in;
         tx_rp_ff     <= tx_rp_in;
         tx_wp_ff     <= tx_wp_in;
         idle_left_ff <= idle_left_in;
         ran_empty_ff <= ran_empty_in;
         burst_ok_ff  <= burst_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ticks_ff <= ubf_pkg::IDLE_TICKS_RESET;
         events_en_ff  <= 1'b0;
      end else if (csr_ch.valid && csr_ch.ready) begin
         unique case (ubf_pkg::reg_type'(csr_ch.index))
            ubf_pkg::REG_IDLE_TICKS:     idle_ticks_ff <= csr_ch.data[ubf_pkg::DATA_W-1:0];
            ubf_pkg::REG_EVENTS_ENABLED: events_en_ff  <= csr_ch.data[0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      pend_ff     <= pend_in;
      src_ff      <= src_in;
   end

   // Drive the response channel
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.read_byte      = rsp_data_ff.read_byte;
   assign rsp_ch.read_valid     = rsp_data_ff.read_valid;
   assign rsp_ch.write_accepted = rsp_data_ff.write_accepted;
   assign rsp_ch.line_byte      = rsp_data_ff.line_byte;
   assign rsp_ch.line_valid     = rsp_data_ff.line_valid;
   assign rsp_ch.rx_overflow    = rsp_data_ff.rx_overflow;
   assign rsp_ch.evt_rx_full    = rsp_data_ff.evt_rx_full;
   assign rsp_ch.evt_rx_timeout = rsp_data_ff.evt_rx_timeout;
   assign rsp_ch.evt_tx_empty   = rsp_data_ff.evt_tx_empty;
   assign rsp_ch.rx_count       = rsp_data_ff.rx_count;

endmodule
